// ----- design/section_time_profiler_table_defines.svh -----
// ----------------------------------------------------------------------------
// Section time profiler table: assertion macros
// Shared concurrent assertion wrappers, clocked on clk and gated by arst_n.
// ----------------------------------------------------------------------------
`ifndef SECTION_TIME_PROFILER_TABLE_DEFINES_SVH
`define SECTION_TIME_PROFILER_TABLE_DEFINES_SVH

// plain property that must hold at every edge out of reset
`define STPT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// same-cycle implication
`define STPT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- design/stpt_pkg.sv -----
// ----------------------------------------------------------------------------
// stpt_pkg
// Types, sizes and codes shared by the section time profiler table.
// ----------------------------------------------------------------------------
package stpt_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int KEY_BITS    = 32;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [1:0] {
		MODE_ENTER = 2'd0,
		MODE_LEAVE = 2'd1,
		MODE_CLEAR = 2'd2,
		MODE_READ  = 2'd3
	} mode_e;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_PUSH
	} state_e;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] section_key;
		logic [31:0] coarse_now;
		logic [63:0] cycle_now;
		logic [5:0]  read_index;
	} item_t;

	typedef struct packed {
		logic [5:0]  entry_index;
		logic        section_active;
		logic        table_full_error;
		logic        newly_inserted;
		logic [6:0]  entries_used;
		logic        entry_valid;
		logic [31:0] entry_key;
		logic [31:0] entry_count;
		logic [31:0] entry_coarse_total;
		logic [63:0] entry_cycle_total;
	} result_t;

	// operation context held by the controller for the whole sweep
	typedef struct packed {
		mode_e               mode;
		logic [KEY_BITS-1:0] key;
		logic [5:0]          read_index;
		logic [31:0]         coarse_delta;
		logic [63:0]         cycle_delta;
		logic                active;
		logic [IDX_W-1:0]    active_idx;
		logic [CNT_W-1:0]    used;
	} bcast_t;

	// request beat walking the cell row
	typedef struct packed {
		logic                vld;
		logic                found;
		logic                inserted;
		logic [IDX_W-1:0]    idx;
		logic                rd_vld;
		logic [KEY_BITS-1:0] rd_key;
		logic [31:0]         rd_count;
		logic [31:0]         rd_coarse;
		logic [63:0]         rd_cycle;
	} tok_t;

endpackage

// ----- design/stpt_if.sv -----
// ----------------------------------------------------------------------------
// stpt_if
// Valid/ready channels for request and result beats.
// ----------------------------------------------------------------------------
interface stpt_item_if;
	logic              valid;
	logic              ready;
	stpt_pkg::item_t   payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface stpt_result_if;
	logic              valid;
	logic              ready;
	stpt_pkg::result_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ----- design/section_time_profiler_table.sv -----
// Section time profiler table. One request beat is taken at a time and
// returns exactly one result beat. Every beat, whatever its mode, walks
// the row of TABLE_DEPTH entry cells one cell per clock, and the next
// request is taken only once the result has moved on into the output
// register. The result is captured in fin_q as the beat leaves the last
// cell, moves into the output register once that register is free, and
// may sit there while the next request is taken. Table entries live in
// the cells and are not cleared by reset; an entry is only ever reported
// after it has been written.

// ----------------------------------------------------------------------------
// section_time_profiler_table
// Top level: controller plus the row of entry cells.
// ----------------------------------------------------------------------------
`include "section_time_profiler_table_defines.svh"

module section_time_profiler_table (
	input  logic           clk,
	input  logic           arst_n,
	stpt_item_if.sink      item,
	stpt_result_if.source  result
);

	stpt_pkg::bcast_t               bc;
	stpt_pkg::tok_t                 tok [stpt_pkg::TABLE_DEPTH+1];
	logic [stpt_pkg::TABLE_DEPTH:0] tok_vld;

	stpt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.result (result),
		.bc     (bc),
		.head   (tok[0]),
		.tail   (tok[stpt_pkg::TABLE_DEPTH])
	);

	for (genvar g = 0; g < stpt_pkg::TABLE_DEPTH; g++) begin : g_cell
		stpt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.idx     (stpt_pkg::IDX_W'(g)),
			.bc      (bc),
			.tok_in  (tok[g]),
			.tok_out (tok[g+1])
		);
	end

	for (genvar v = 0; v <= stpt_pkg::TABLE_DEPTH; v++) begin : g_vld
		assign tok_vld[v] = tok[v].vld;
	end

	`STPT_ASSERT(a_one_beat, $onehot0(tok_vld), "more than one beat in the cell row")
	`STPT_ASSERT_IMP(a_busy_no_accept, |tok_vld, !item.ready, "request taken during a sweep")
	`STPT_ASSERT_IMP(a_err_excl, result.valid, !(result.payload.table_full_error && result.payload.newly_inserted), "full error together with insert")
	`STPT_ASSERT_IMP(a_used_bound, result.valid, int'(result.payload.entries_used) <= stpt_pkg::TABLE_DEPTH, "entry count beyond table depth")

endmodule

// ----- design/stpt_cell.sv -----
// ----------------------------------------------------------------------------
// stpt_cell
// One table entry: key, visit count and totals, plus one stage of the
// request beat that walks the row.
// ----------------------------------------------------------------------------
module stpt_cell (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [stpt_pkg::IDX_W-1:0]      idx,
	input  stpt_pkg::bcast_t                bc,
	input  stpt_pkg::tok_t                  tok_in,
	output stpt_pkg::tok_t                  tok_out
);

	logic [stpt_pkg::KEY_BITS-1:0] key_q;
	logic [31:0]                   count_q;
	logic [31:0]                   coarse_q;
	logic [63:0]                   cycle_q;
	stpt_pkg::tok_t                tok_q;
	stpt_pkg::tok_t                tok_d;

	logic here_used;
	logic is_enter;
	logic do_match;
	logic do_insert;
	logic do_close;
	logic do_read;

	always_comb begin
		here_used = stpt_pkg::CNT_W'(idx) < bc.used;
		is_enter  = bc.mode == stpt_pkg::MODE_ENTER;
		do_match  = tok_in.vld && is_enter && !tok_in.found && here_used && key_q == bc.key;
		// first free slot; earlier cells have all been checked by now
		do_insert = tok_in.vld && is_enter && !tok_in.found
			&& stpt_pkg::CNT_W'(idx) == bc.used;
		do_close  = tok_in.vld && bc.active && bc.active_idx == idx
			&& (bc.mode == stpt_pkg::MODE_ENTER || bc.mode == stpt_pkg::MODE_LEAVE);
		do_read   = tok_in.vld && bc.mode == stpt_pkg::MODE_READ && here_used
			&& int'(idx) == int'(bc.read_index);
	end

	always_comb begin
		tok_d = tok_in;
		if (do_match || do_insert) begin
			tok_d.found = 1'b1;
			tok_d.idx   = idx;
		end
		if (do_insert) begin
			tok_d.inserted = 1'b1;
		end
		if (do_read) begin
			tok_d.rd_vld    = 1'b1;
			tok_d.rd_key    = key_q;
			tok_d.rd_count  = count_q;
			tok_d.rd_coarse = coarse_q;
			tok_d.rd_cycle  = cycle_q;
		end
	end

	always_ff @(posedge clk) begin
		if (do_insert) begin
			key_q    <= bc.key;
			count_q  <= '0;
			coarse_q <= '0;
			cycle_q  <= '0;
		end else if (do_close) begin
			count_q  <= count_q + 32'd1;
			coarse_q <= coarse_q + bc.coarse_delta;
			cycle_q  <= cycle_q + bc.cycle_delta;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	assign tok_out = tok_q;

endmodule

// ----- design/stpt_ctrl.sv -----
// ----------------------------------------------------------------------------
// stpt_ctrl
// Request intake, active-section bookkeeping, beat launch into the cell
// row and the result register.
// ----------------------------------------------------------------------------
module stpt_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	stpt_item_if.sink              item,
	stpt_result_if.source          result,
	output stpt_pkg::bcast_t       bc,
	output stpt_pkg::tok_t         head,
	input  stpt_pkg::tok_t         tail
);

	stpt_pkg::state_e state_q;
	stpt_pkg::state_e state_d;

	logic                          accept;
	logic                          load_out;

	// op context, captured on accept
	stpt_pkg::mode_e               mode_q;
	logic [stpt_pkg::KEY_BITS-1:0] key_q;
	logic [5:0]                    ridx_q;
	logic [31:0]                   dcoarse_q;
	logic [63:0]                   dcycle_q;
	logic [31:0]                   coarse_now_q;
	logic [63:0]                   cycle_now_q;
	logic                          head_vld_q;

	// profiler state
	logic                          active_q;
	logic [stpt_pkg::IDX_W-1:0]    act_idx_q;
	logic [stpt_pkg::CNT_W-1:0]    used_q;
	logic [31:0]                   coarse_start_q;
	logic [63:0]                   cycle_start_q;

	logic                          active_d;
	logic [stpt_pkg::IDX_W-1:0]    act_idx_d;
	logic [stpt_pkg::CNT_W-1:0]    used_d;
	logic                          restart;

	logic [31:0]                   dcoarse;
	logic [63:0]                   dcycle;

	stpt_pkg::result_t             fin_q;
	stpt_pkg::result_t             fin_d;
	stpt_pkg::result_t             res_q;
	logic                          res_vld_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			stpt_pkg::ST_IDLE:  if (accept) state_d = stpt_pkg::ST_SWEEP;
			stpt_pkg::ST_SWEEP: if (tail.vld) state_d = stpt_pkg::ST_PUSH;
			stpt_pkg::ST_PUSH:  if (!res_vld_q || result.ready) state_d = stpt_pkg::ST_IDLE;
			default:            state_d = stpt_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		item.ready = state_q == stpt_pkg::ST_IDLE;
		load_out   = state_q == stpt_pkg::ST_PUSH && (!res_vld_q || result.ready);
	end

	assign accept = item.valid && item.ready;

	// positive part of elapsed time, taken against the current start
	always_comb begin
		dcoarse = item.payload.coarse_now - coarse_start_q;
		dcycle  = item.payload.cycle_now - cycle_start_q;
		if (dcoarse == '0 || dcoarse[31]) dcoarse = '0;
		if (dcycle == '0 || dcycle[63]) dcycle = '0;
	end

	// bookkeeping once the beat leaves the row
	always_comb begin
		active_d  = active_q;
		act_idx_d = act_idx_q;
		used_d    = used_q;
		restart   = 1'b0;
		unique case (mode_q)
			stpt_pkg::MODE_ENTER: begin
				active_d = tail.found;
				if (tail.found) begin
					act_idx_d = tail.idx;
					restart   = 1'b1;
				end
				if (tail.inserted) used_d = used_q + stpt_pkg::CNT_W'(1);
			end
			stpt_pkg::MODE_LEAVE: begin
				active_d = 1'b0;
			end
			stpt_pkg::MODE_CLEAR: begin
				active_d = 1'b0;
				used_d   = '0;
			end
			stpt_pkg::MODE_READ: begin
			end
			default: begin
			end
		endcase

		fin_d.section_active     = active_d;
		fin_d.table_full_error   = mode_q == stpt_pkg::MODE_ENTER && !tail.found;
		fin_d.newly_inserted     = tail.inserted;
		fin_d.entries_used       = 7'(used_d);
		fin_d.entry_valid        = tail.rd_vld;
		fin_d.entry_key          = 32'(tail.rd_key);
		fin_d.entry_count        = tail.rd_count;
		fin_d.entry_coarse_total = tail.rd_coarse;
		fin_d.entry_cycle_total  = tail.rd_cycle;
		if (mode_q == stpt_pkg::MODE_READ) begin
			fin_d.entry_index = ridx_q;
		end else if (active_d) begin
			fin_d.entry_index = 6'(act_idx_d);
		end else begin
			fin_d.entry_index = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q       <= stpt_pkg::mode_e'(item.payload.mode);
			key_q        <= stpt_pkg::KEY_BITS'(item.payload.section_key);
			ridx_q       <= item.payload.read_index;
			dcoarse_q    <= dcoarse;
			dcycle_q     <= dcycle;
			coarse_now_q <= item.payload.coarse_now;
			cycle_now_q  <= item.payload.cycle_now;
		end
		if (tail.vld) fin_q <= fin_d;
		if (load_out) res_q <= fin_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= stpt_pkg::ST_IDLE;
			head_vld_q     <= 1'b0;
			active_q       <= 1'b0;
			act_idx_q      <= '0;
			used_q         <= '0;
			coarse_start_q <= '0;
			cycle_start_q  <= '0;
			res_vld_q      <= 1'b0;
		end else begin
			state_q    <= state_d;
			head_vld_q <= accept;
			if (tail.vld) begin
				active_q  <= active_d;
				act_idx_q <= act_idx_d;
				used_q    <= used_d;
				if (restart) begin
					coarse_start_q <= coarse_now_q;
					cycle_start_q  <= cycle_now_q;
				end
			end
			if (load_out) begin
				res_vld_q <= 1'b1;
			end else if (result.ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	always_comb begin
		bc.mode         = mode_q;
		bc.key          = key_q;
		bc.read_index   = ridx_q;
		bc.coarse_delta = dcoarse_q;
		bc.cycle_delta  = dcycle_q;
		bc.active       = active_q;
		bc.active_idx   = act_idx_q;
		bc.used         = used_q;
	end

	always_comb begin
		head     = '0;
		head.vld = head_vld_q;
	end

	assign result.valid   = res_vld_q;
	assign result.payload = res_q;

endmodule

// ----- tb/section_time_profiler_table_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// section_time_profiler_table_tb
// Self-checking bench for the section time profiler table. A short table of
// hand-picked requests runs first, then random segments of enter, leave, read
// and clear traffic over small key pools and pools big enough to fill the
// table. Every result beat is compared field by field with its hand-picked
// expectation or an in-bench model of the table, under random stalls on both channels.
// ----------------------------------------------------------------------------
module section_time_profiler_table_tb;

	localparam int ITEM_GOAL = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	stpt_item_if   item_ch();
	stpt_result_if result_ch();

	section_time_profiler_table u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	typedef struct packed {
		stpt_pkg::mode_e   mode;
		logic [31:0]       key;
		logic [31:0]       coarse;
		logic [63:0]       cycles;
		logic [5:0]        ridx;
		logic              typed;
		stpt_pkg::result_t want;
	} probe_t;

	// model of the table
	logic [31:0] sec_key    [stpt_pkg::TABLE_DEPTH];
	logic [31:0] sec_visits [stpt_pkg::TABLE_DEPTH];
	logic [31:0] sec_coarse [stpt_pkg::TABLE_DEPTH];
	logic [63:0] sec_cycles [stpt_pkg::TABLE_DEPTH];
	int          n_used = 0;
	logic [5:0]  open_slot = '0;
	logic        sec_open = 1'b0;
	logic [31:0] start_coarse = '0;
	logic [63:0] start_cycle = '0;

	stpt_pkg::result_t profile_due[$];
	probe_t            probes[$];
	int                faults = 0;
	int                sent = 0;
	int                holds_asked = 0;
	int                tx_calm_left = 0;
	logic [31:0]       wall_coarse = '0;
	logic [63:0]       wall_cycles = '0;

	function automatic stpt_pkg::result_t profile_step(input stpt_pkg::item_t it);
		stpt_pkg::result_t r;
		logic [31:0]       d_coarse;
		logic [63:0]       d_cycle;
		int                slot;
		int                i;
		r = '0;
		slot = -1;
		if (it.mode == stpt_pkg::MODE_ENTER || it.mode == stpt_pkg::MODE_LEAVE) begin
			if (sec_open) begin
				d_coarse = it.coarse_now - start_coarse;
				d_cycle  = it.cycle_now - start_cycle;
				// only forward progress counts; wrapped-back stamps add nothing
				if (d_coarse != 0 && !d_coarse[31])
					sec_coarse[open_slot] += d_coarse;
				if (d_cycle != 0 && !d_cycle[63])
					sec_cycles[open_slot] += d_cycle;
				sec_visits[open_slot] += 32'd1;
			end
			sec_open = 1'b0;
			if (it.mode == stpt_pkg::MODE_ENTER) begin
				for (i = 0; i < n_used; i++)
					if (slot < 0 && sec_key[6'(i)] == it.section_key)
						slot = i;
				if (slot < 0 && n_used < stpt_pkg::TABLE_DEPTH) begin
					slot = n_used;
					sec_key[6'(slot)]    = it.section_key;
					sec_visits[6'(slot)] = '0;
					sec_coarse[6'(slot)] = '0;
					sec_cycles[6'(slot)] = '0;
					n_used++;
					r.newly_inserted = 1'b1;
				end
				if (slot < 0) begin
					r.table_full_error = 1'b1;
				end else begin
					open_slot    = 6'(slot);
					sec_open     = 1'b1;
					start_coarse = it.coarse_now;
					start_cycle  = it.cycle_now;
				end
			end
		end else if (it.mode == stpt_pkg::MODE_CLEAR) begin
			// totals stay in the store; only the fill level and the open section drop
			n_used   = 0;
			sec_open = 1'b0;
		end
		if (it.mode == stpt_pkg::MODE_READ) begin
			r.entry_index = it.read_index;
			if (int'(it.read_index) < n_used) begin
				r.entry_valid        = 1'b1;
				r.entry_key          = sec_key[it.read_index];
				r.entry_count        = sec_visits[it.read_index];
				r.entry_coarse_total = sec_coarse[it.read_index];
				r.entry_cycle_total  = sec_cycles[it.read_index];
			end
		end else begin
			r.entry_index = sec_open ? open_slot : 6'd0;
		end
		r.section_active = sec_open;
		r.entries_used   = 7'(n_used);
		return r;
	endfunction

	function automatic stpt_pkg::result_t report(input int idx, input bit act,
			input bit full, input bit ins, input int used, input bit vld,
			input logic [31:0] k, input logic [31:0] n, input logic [31:0] c,
			input logic [63:0] y);
		stpt_pkg::result_t r;
		r.entry_index        = 6'(idx);
		r.section_active     = act;
		r.table_full_error   = full;
		r.newly_inserted     = ins;
		r.entries_used       = 7'(used);
		r.entry_valid        = vld;
		r.entry_key          = k;
		r.entry_count        = n;
		r.entry_coarse_total = c;
		r.entry_cycle_total  = y;
		return r;
	endfunction

	function automatic int field_diff(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
			return 1;
		end
		return 0;
	endfunction

	function automatic int pick_gap();
		int roll;
		if (tx_calm_left > 0) begin
			tx_calm_left--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 45)
			return 0;
		if (roll < 80)
			return $urandom_range(1, 3);
		if (roll < 93)
			return $urandom_range(4, 80);
		if (roll < 97)
			return $urandom_range(100, 300);
		tx_calm_left = $urandom_range(30, 100);
		return 0;
	endfunction

	// called at a falling edge; returns at the falling edge after the beat is taken
	task automatic push_item(input stpt_pkg::item_t it, input logic typed,
			input stpt_pkg::result_t want);
		int                gap;
		stpt_pkg::result_t r;
		gap = pick_gap();
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid   <= 1'b1;
		item_ch.payload <= it;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		r = profile_step(it);
		profile_due.push_back(typed ? want : r);
		sent++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		item_ch.valid <= 1'b0;
		while (profile_due.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_op(input stpt_pkg::mode_e m, input logic [31:0] key);
		stpt_pkg::item_t it;
		int              roll;
		if (sent == 700)
			holds_asked++;
		if (sent == 1300)
			drain_results();
		roll = $urandom_range(0, 99);
		// stamps mostly creep forward; rare jumps give wrapped and huge deltas
		if (roll < 4)
			wall_coarse = $urandom;
		else
			wall_coarse += $urandom_range(0, 3);
		if (roll >= 2 && roll < 6)
			wall_cycles = {$urandom, $urandom};
		else
			wall_cycles += 64'($urandom_range(0, 4000));
		it.mode        = m;
		it.section_key = key;
		it.coarse_now  = wall_coarse;
		it.cycle_now   = wall_cycles;
		if (n_used > 0 && $urandom_range(0, 3) != 0)
			it.read_index = 6'($urandom_range(0, n_used - 1));
		else
			it.read_index = 6'($urandom_range(0, 63));
		push_item(it, 1'b0, '0);
	endtask

	task automatic run_segment();
		logic [31:0]     keys[$];
		int              pool_n;
		int              len;
		int              roll;
		int              i;
		bit              fill;
		stpt_pkg::mode_e m;
		logic [31:0]     k;
		fill   = ($urandom_range(0, 5) == 0);
		pool_n = fill ? $urandom_range(64, 72) : $urandom_range(1, 12);
		for (i = 0; i < pool_n; i++)
			keys.push_back($urandom);
		if (fill || $urandom_range(0, 1) == 1)
			send_op(stpt_pkg::MODE_CLEAR, keys[0]);
		// walk the pool in order so the table really fills up
		if (fill) begin
			for (i = 0; i < pool_n; i++) begin
				send_op(stpt_pkg::MODE_ENTER, keys[i]);
				if ($urandom_range(0, 4) == 0)
					send_op($urandom_range(0, 1) ? stpt_pkg::MODE_READ
						: stpt_pkg::MODE_LEAVE, keys[i]);
			end
		end
		len = $urandom_range(10, 60);
		repeat (len) begin
			roll = $urandom_range(0, 99);
			if (roll < 42)
				m = stpt_pkg::MODE_ENTER;
			else if (roll < 57)
				m = stpt_pkg::MODE_LEAVE;
			else if (roll < 95)
				m = stpt_pkg::MODE_READ;
			else
				m = stpt_pkg::MODE_CLEAR;
			k = ($urandom_range(0, 9) == 0) ? $urandom : keys[$urandom_range(0, pool_n - 1)];
			send_op(m, k);
		end
		if ($urandom_range(0, 4) == 0)
			drain_results();
	endtask

	task automatic load_probes();
		probes.push_back('{stpt_pkg::MODE_READ, 32'h0, 32'h0, 64'h0, 6'd0, 1'b1,
			report(0, 0, 0, 0, 0, 0, 0, 0, 0, 0)});
		probes.push_back('{stpt_pkg::MODE_READ, 32'h0, 32'h0, 64'h0, 6'd63, 1'b1,
			report(63, 0, 0, 0, 0, 0, 0, 0, 0, 0)});
		// leave with nothing open
		probes.push_back('{stpt_pkg::MODE_LEAVE, 32'h0, 32'h0, 64'h0, 6'd0, 1'b1,
			report(0, 0, 0, 0, 0, 0, 0, 0, 0, 0)});
		probes.push_back('{stpt_pkg::MODE_CLEAR, 32'h0, 32'h0, 64'h0, 6'd0, 1'b1,
			report(0, 0, 0, 0, 0, 0, 0, 0, 0, 0)});
		probes.push_back('{stpt_pkg::MODE_ENTER, 32'hFFFF_FFFF, 32'h0, 64'h0, 6'd0, 1'b1,
			report(0, 1, 0, 1, 1, 0, 0, 0, 0, 0)});
		probes.push_back('{stpt_pkg::MODE_ENTER, 32'hFFFF_FFFF, 32'd100, 64'd1000, 6'd0,
			1'b1, report(0, 1, 0, 0, 1, 0, 0, 0, 0, 0)});
		probes.push_back('{stpt_pkg::MODE_READ, 32'h0, 32'h0, 64'h0, 6'd0, 1'b1,
			report(0, 1, 0, 0, 1, 1, 32'hFFFF_FFFF, 1, 100, 1000)});
		// largest positive deltas, then deltas that went backwards, then zero
		probes.push_back('{stpt_pkg::MODE_ENTER, 32'h0, 32'h8000_0063,
			64'h8000_0000_0000_03E7, 6'd0, 1'b0, stpt_pkg::result_t'('0)});
		probes.push_back('{stpt_pkg::MODE_ENTER, 32'h0, 32'h63, 64'h3E7, 6'd0, 1'b0,
			stpt_pkg::result_t'('0)});
		probes.push_back('{stpt_pkg::MODE_ENTER, 32'h0, 32'h63, 64'h3E7, 6'd0, 1'b0,
			stpt_pkg::result_t'('0)});
		probes.push_back('{stpt_pkg::MODE_LEAVE, 32'h0, 32'hFFFF_FFFF,
			64'hFFFF_FFFF_FFFF_FFFF, 6'd0, 1'b0, stpt_pkg::result_t'('0)});
		probes.push_back('{stpt_pkg::MODE_LEAVE, 32'h0, 32'h0, 64'h0, 6'd0, 1'b1,
			report(0, 0, 0, 0, 2, 0, 0, 0, 0, 0)});
		probes.push_back('{stpt_pkg::MODE_READ, 32'h0, 32'h0, 64'h0, 6'd0, 1'b0,
			stpt_pkg::result_t'('0)});
		probes.push_back('{stpt_pkg::MODE_READ, 32'h0, 32'h0, 64'h0, 6'd1, 1'b0,
			stpt_pkg::result_t'('0)});
		probes.push_back('{stpt_pkg::MODE_READ, 32'h0, 32'h0, 64'h0, 6'd2, 1'b1,
			report(2, 0, 0, 0, 2, 0, 0, 0, 0, 0)});
		probes.push_back('{stpt_pkg::MODE_ENTER, 32'h5A5A_5A5A, 32'h10, 64'h20, 6'd0, 1'b0,
			stpt_pkg::result_t'('0)});
		probes.push_back('{stpt_pkg::MODE_ENTER, 32'hA5A5_A5A5, 32'h7FFF_0000,
			64'h1234_5678_9ABC, 6'd0, 1'b0, stpt_pkg::result_t'('0)});
		probes.push_back('{stpt_pkg::MODE_READ, 32'h0, 32'h0, 64'h0, 6'd63, 1'b1,
			report(63, 1, 0, 0, 4, 0, 0, 0, 0, 0)});
		// clear drops the open section without closing it
		probes.push_back('{stpt_pkg::MODE_CLEAR, 32'h0, 32'h0, 64'h0, 6'd0, 1'b1,
			report(0, 0, 0, 0, 0, 0, 0, 0, 0, 0)});
		probes.push_back('{stpt_pkg::MODE_READ, 32'h0, 32'h0, 64'h0, 6'd0, 1'b1,
			report(0, 0, 0, 0, 0, 0, 0, 0, 0, 0)});
		probes.push_back('{stpt_pkg::MODE_LEAVE, 32'h0, 32'h5, 64'h5, 6'd0, 1'b1,
			report(0, 0, 0, 0, 0, 0, 0, 0, 0, 0)});
		// reused slot starts from zeroed totals
		probes.push_back('{stpt_pkg::MODE_ENTER, 32'h0, 32'h9, 64'h9, 6'd0, 1'b1,
			report(0, 1, 0, 1, 1, 0, 0, 0, 0, 0)});
		probes.push_back('{stpt_pkg::MODE_READ, 32'h0, 32'h0, 64'h0, 6'd0, 1'b1,
			report(0, 1, 0, 0, 1, 1, 0, 0, 0, 0)});
	endtask

	initial begin
		stpt_pkg::item_t it;
		item_ch.valid   = 1'b0;
		item_ch.payload = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		load_probes();
		foreach (probes[n]) begin
			it.mode        = probes[n].mode;
			it.section_key = probes[n].key;
			it.coarse_now  = probes[n].coarse;
			it.cycle_now   = probes[n].cycles;
			it.read_index  = probes[n].ridx;
			push_item(it, probes[n].typed, probes[n].want);
		end
		while (sent < ITEM_GOAL)
			run_segment();
		drain_results();
		// room for a stray beat after the last one expected
		repeat (80) @(posedge clk);
		if (faults == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// result side back-pressure
	initial begin
		int stall_left;
		int calm_left;
		int holds_done;
		int roll;
		stall_left = 0;
		calm_left  = 0;
		holds_done = 0;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (holds_done < holds_asked) begin
				// long hold so the block backs up into its request port
				holds_done++;
				stall_left = 1500;
				calm_left  = 0;
			end
			if (stall_left > 0) begin
				result_ch.ready <= 1'b0;
				stall_left--;
			end else if (calm_left > 0) begin
				result_ch.ready <= 1'b1;
				calm_left--;
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 70) begin
					result_ch.ready <= 1'b1;
				end else if (roll < 93) begin
					result_ch.ready <= 1'b0;
					stall_left = $urandom_range(0, 2);
				end else if (roll < 96) begin
					result_ch.ready <= 1'b0;
					stall_left = $urandom_range(10, 150);
				end else begin
					result_ch.ready <= 1'b1;
					calm_left = $urandom_range(100, 600);
				end
			end
		end
	end

	always @(posedge clk) begin
		stpt_pkg::result_t want;
		stpt_pkg::result_t got;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = result_ch.payload;
			if (profile_due.size() == 0) begin
				$display("%0t: result beat with nothing outstanding, got 0x%0h", $time, got);
				faults++;
			end else begin
				want = profile_due.pop_front();
				faults += field_diff("entry_index", 64'(want.entry_index),
					64'(got.entry_index));
				faults += field_diff("section_active", 64'(want.section_active),
					64'(got.section_active));
				faults += field_diff("table_full_error", 64'(want.table_full_error),
					64'(got.table_full_error));
				faults += field_diff("newly_inserted", 64'(want.newly_inserted),
					64'(got.newly_inserted));
				faults += field_diff("entries_used", 64'(want.entries_used),
					64'(got.entries_used));
				faults += field_diff("entry_valid", 64'(want.entry_valid),
					64'(got.entry_valid));
				faults += field_diff("entry_key", 64'(want.entry_key), 64'(got.entry_key));
				faults += field_diff("entry_count", 64'(want.entry_count),
					64'(got.entry_count));
				faults += field_diff("entry_coarse_total", 64'(want.entry_coarse_total),
					64'(got.entry_coarse_total));
				faults += field_diff("entry_cycle_total", want.entry_cycle_total,
					got.entry_cycle_total);
			end
		end
	end

	// timeout well beyond the worst case of all beats with their largest gaps and
	// stalls plus the long holds
	initial begin
		#40_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
